>>> hw/rtl/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic shift_bit;
        logic shift_digit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic conv_done;
        logic lead_zero;
        logic last_digit;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/binary_to_decimal_ascii_digits_top.sv
`default_nettype none

// Converts one unsigned NUMBER_WIDTH-bit number per input beat into its decimal
// digits as ASCII characters, most significant first, without leading zeros (zero
// gives a single '0'); o_last marks the final digit. One number is worked at a time:
// after the input beat a shift-and-add-3 BCD converter runs over all NUMBER_WIDTH bits,
// then the leading zero digits are shifted out and dropped, then one digit goes out
// per cycle that the output is not stalled. The next number is taken only after the
// last digit has gone out. If the value needs more than MAX_DIGITS digits only the
// lowest MAX_DIGITS are sent, leading zeros included.
module binary_to_decimal_ascii_digits_top #(
    parameter int NUMBER_WIDTH = 32,
    parameter int MAX_DIGITS   = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [NUMBER_WIDTH-1:0]      i_number,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                              o_last
);
    import b2da_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    b2da_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    b2da_datapath #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_number     (i_number),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

>>> hw/rtl/b2da_datapath.sv
`default_nettype none

module b2da_datapath #(
    parameter int NUMBER_WIDTH = 32,
    parameter int MAX_DIGITS   = 10
) (
    input  wire logic                         i_clk,
    input  wire logic [NUMBER_WIDTH-1:0]      i_number,
    input  wire b2da_pkg::t_dp_cmd            i_cmd,
    output b2da_pkg::t_dp_status              o_status,
    output logic [b2da_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                              o_last
);
    import b2da_pkg::*;

    localparam int BCD_W     = DIGIT_W * MAX_DIGITS;
    localparam int BIT_CNT_W = $clog2(NUMBER_WIDTH);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

    logic [NUMBER_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]        r_bcd, n_bcd;
    logic                    r_ovf, n_ovf;
    logic [BIT_CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [DIG_CNT_W-1:0]    r_dig_cnt, n_dig_cnt;

    logic [BCD_W-1:0]        bcd_adj;
    logic [DIGIT_W-1:0]      top_digit;

    // add 3 to every digit of 5 or more before the doubling shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

    always_comb begin
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_ovf     = r_ovf;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        if (i_cmd.load) begin
            n_bin     = i_number;
            n_bcd     = '0;
            n_ovf     = 1'b0;
            n_bit_cnt = '0;
            n_dig_cnt = DIG_CNT_W'(MAX_DIGITS);
        end else if (i_cmd.shift_bit) begin
            // a carry out of the top digit means the value has more digits than fit
            n_bcd     = {bcd_adj[BCD_W-2:0], r_bin[NUMBER_WIDTH-1]};
            n_ovf     = r_ovf | bcd_adj[BCD_W-1];
            n_bin     = {r_bin[NUMBER_WIDTH-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
        end else if (i_cmd.shift_digit) begin
            n_bcd     = {r_bcd[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
            n_dig_cnt = r_dig_cnt - DIG_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_ovf     <= n_ovf;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
    end

    always_comb begin
        o_status.conv_done  = (r_bit_cnt == BIT_CNT_W'(NUMBER_WIDTH - 1));
        o_status.last_digit = (r_dig_cnt == DIG_CNT_W'(1));
        // keep leading zeros only when digits were dropped off the top
        o_status.lead_zero  = (top_digit == '0) && !o_status.last_digit && !r_ovf;
    end

    assign o_digit_char = ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, top_digit};
    assign o_last       = o_status.last_digit;

endmodule

`default_nettype wire

>>> hw/rtl/b2da_ctrl.sv
`default_nettype none

module b2da_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    input  wire b2da_pkg::t_dp_status  i_status,
    output b2da_pkg::t_dp_cmd          o_cmd
);
    import b2da_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (i_status.conv_done) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!i_status.lead_zero) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stall && i_status.last_digit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_CONVERT: begin
                o_cmd.shift_bit = 1'b1;
            end
            ST_SKIP: begin
                o_cmd.shift_digit = i_status.lead_zero;
            end
            ST_EMIT: begin
                // advance to the next digit once the beat is taken
                o_valid           = 1'b1;
                o_cmd.shift_digit = !i_stall;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/b2da_checker.sv
`default_nettype none

module b2da_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [5:0] o_digit_char,
    input wire logic       o_last
);

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57))
        else $error("digit character out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_char) && $stable(o_last))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while a conversion is in progress");

    a_no_input_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while digits are pending");

endmodule

bind binary_to_decimal_ascii_digits_top b2da_checker u_b2da_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_digit_char (o_digit_char),
    .o_last       (o_last)
);

`default_nettype wire
